/* sv/assert_macros.svh */
// Assertion macros shared by the speckle filter RTL.
// Depends on a clock named clk and an active-low reset named rst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked at every rising clock edge out of reset.
`define WDSF_ASSERT_IMP(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("wdsf assertion failed");

// Next-cycle implication, checked at every rising clock edge out of reset.
`define WDSF_ASSERT_NXT(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("wdsf assertion failed");

`endif

/* sv/wdsf_pkg.sv */
// Shared constants, codes and control structs of the speckle filter.
// Used by the interfaces, controller, datapath and top level; no dependencies.
package wdsf_pkg;

  // Frame geometry and window size.
  localparam int MAX_WIDTH  = 256;
  localparam int MAX_HEIGHT = 256;
  localparam int RADIUS     = 20;

  // Field widths of the channels and registers.
  localparam int KIND_W  = 2;
  localparam int ROW_W   = $clog2(MAX_HEIGHT);
  localparam int COL_W   = $clog2(MAX_WIDTH);
  localparam int PIX_W   = 16;
  localparam int KEEP_W  = 13;
  localparam int DIM_W   = 9;
  localparam int CFG_W   = 16;
  localparam int CFG_IDX_W = 2;
  localparam int ADDR_W  = ROW_W + COL_W;
  localparam int DEPTH   = MAX_WIDTH * MAX_HEIGHT;

  // Window pixel count and the width used to compare it with the threshold.
  localparam int CNT_W = $clog2(4 * RADIUS * RADIUS + 1);
  localparam int CMP_W = (CNT_W > KEEP_W) ? CNT_W : KEEP_W;

  // Item kinds.
  localparam logic [KIND_W-1:0] KIND_WRITE = 2'd0;
  localparam logic [KIND_W-1:0] KIND_RUN   = 2'd1;
  localparam logic [KIND_W-1:0] KIND_READ  = 2'd2;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_MATCH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_KEEP   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_WIDTH  = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT = 2'd3;

  // Reset values of the configuration registers.
  localparam logic [PIX_W-1:0]  MATCH_RST  = 16'd255;
  localparam logic [KEEP_W-1:0] KEEP_RST   = 13'd150;
  localparam logic [DIM_W-1:0]  WIDTH_RST  = 9'd256;
  localparam logic [DIM_W-1:0]  HEIGHT_RST = 9'd256;

  // Source of the frame store read address.
  typedef enum logic [1:0] {
    RD_ITEM,
    RD_CTR,
    RD_WIN
  } rd_src_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic    item_load;
    logic    item_wr;
    logic    rd_en;
    rd_src_t rd_src;
    logic    run_init;
    logic    win_init;
    logic    win_step;
    logic    clear_wr;
    logic    ctr_step;
    logic    out_load;
  } dp_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic size_ok;
    logic ctr_fg;
    logic win_last;
    logic keep_low;
    logic ctr_last;
  } dp_sts_t;

endpackage

/* sv/wdsf_in_if.sv */
// Input channel of the speckle filter: valid/ready handshake and item fields.
// Depends on wdsf_pkg for the field widths.
interface wdsf_in_if;
  logic                         valid;
  logic                         ready;
  logic [wdsf_pkg::KIND_W-1:0]  kind;
  logic [wdsf_pkg::ROW_W-1:0]   row;
  logic [wdsf_pkg::COL_W-1:0]   col;
  logic [wdsf_pkg::PIX_W-1:0]   value;

  modport source (output valid, kind, row, col, value, input ready);
  modport sink   (input valid, kind, row, col, value, output ready);
endinterface

/* sv/wdsf_out_if.sv */
// Result channel of the speckle filter: valid/ready handshake and result fields.
// Depends on wdsf_pkg for the field widths.
interface wdsf_out_if;
  logic                        valid;
  logic                        ready;
  logic [wdsf_pkg::PIX_W-1:0]  read_value;
  logic                        done_res;

  modport source (output valid, read_value, done_res, input ready);
  modport sink   (input valid, read_value, done_res, output ready);
endinterface

/* sv/wdsf_ram.sv */
// Generic simple dual-port RAM: one write port and one registered read port.
// No dependencies; contents are undefined until written.
module wdsf_ram #(
  parameter int DataW = 16,
  parameter int Depth = 65536
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] waddr,
  input  logic [DataW-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(Depth)-1:0] raddr,
  output logic [DataW-1:0]         rdata
);

  logic [DataW-1:0] mem_r [Depth];
  logic [DataW-1:0] rdata_r;

  // Write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
  end

  // Registered read port; the data holds while no read is enabled.
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

/* sv/wdsf_ctrl.sv */
// Controller state machine of the speckle filter: handshakes and run sequencing.
// Depends on wdsf_pkg for the command and status structs.
module wdsf_ctrl (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  input  logic [wdsf_pkg::KIND_W-1:0] in_kind,
  output logic                        in_ready,
  output logic                        out_valid,
  input  logic                        out_ready,
  output wdsf_pkg::dp_cmd_t           cmd,
  input  wdsf_pkg::dp_sts_t           sts
);

  localparam logic [3:0] S_IDLE     = 4'd0;
  localparam logic [3:0] S_WR       = 4'd1;
  localparam logic [3:0] S_RD       = 4'd2;
  localparam logic [3:0] S_RUN_INIT = 4'd3;
  localparam logic [3:0] S_CTR_RD   = 4'd4;
  localparam logic [3:0] S_CTR_CHK  = 4'd5;
  localparam logic [3:0] S_WIN      = 4'd6;
  localparam logic [3:0] S_WIN_LAST = 4'd7;
  localparam logic [3:0] S_DECIDE   = 4'd8;
  localparam logic [3:0] S_NEXT     = 4'd9;
  localparam logic [3:0] S_DONE     = 4'd10;

  logic [3:0] state_r, state_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic       accept;
  logic       slot_free;

  assign in_ready  = (state_r == S_IDLE);
  assign accept    = in_valid && in_ready;
  assign slot_free = !out_valid_r || out_ready;
  assign out_valid = out_valid_r;

  // Next state and datapath commands.
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    cmd.rd_src = wdsf_pkg::RD_ITEM;
    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          cmd.item_load = 1'b1;
          priority if (in_kind == wdsf_pkg::KIND_WRITE) begin
            state_nxt = S_WR;
          end else if (in_kind == wdsf_pkg::KIND_RUN) begin
            state_nxt = S_RUN_INIT;
          end else if (in_kind == wdsf_pkg::KIND_READ) begin
            state_nxt = S_RD;
          end else begin
            state_nxt = S_DONE;
          end
        end
      end
      S_WR: begin
        cmd.item_wr = 1'b1;
        state_nxt   = S_DONE;
      end
      S_RD: begin
        cmd.rd_en  = 1'b1;
        cmd.rd_src = wdsf_pkg::RD_ITEM;
        state_nxt  = S_DONE;
      end
      S_RUN_INIT: begin
        cmd.run_init = 1'b1;
        state_nxt    = sts.size_ok ? S_CTR_RD : S_DONE;
      end
      S_CTR_RD: begin
        cmd.rd_en  = 1'b1;
        cmd.rd_src = wdsf_pkg::RD_CTR;
        state_nxt  = S_CTR_CHK;
      end
      S_CTR_CHK: begin
        if (sts.ctr_fg) begin
          cmd.win_init = 1'b1;
          state_nxt    = S_WIN;
        end else begin
          state_nxt = S_NEXT;
        end
      end
      S_WIN: begin
        // One window read per cycle; the count takes in each pixel in the cycle after its read.
        cmd.rd_en    = 1'b1;
        cmd.rd_src   = wdsf_pkg::RD_WIN;
        cmd.win_step = 1'b1;
        if (sts.win_last) begin
          state_nxt = S_WIN_LAST;
        end
      end
      S_WIN_LAST: begin
        state_nxt = S_DECIDE;
      end
      S_DECIDE: begin
        cmd.clear_wr = sts.keep_low;
        state_nxt    = S_NEXT;
      end
      S_NEXT: begin
        if (sts.ctr_last) begin
          state_nxt = S_DONE;
        end else begin
          cmd.ctr_step = 1'b1;
          state_nxt    = S_CTR_RD;
        end
      end
      S_DONE: begin
        if (slot_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Output beat valid flag.
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

/* sv/wdsf_dp.sv */
// Datapath of the speckle filter: registers, frame store, coordinates and counter.
// Depends on wdsf_pkg and wdsf_ram.
module wdsf_dp (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic [wdsf_pkg::KIND_W-1:0]    in_kind,
  input  logic [wdsf_pkg::ROW_W-1:0]     in_row,
  input  logic [wdsf_pkg::COL_W-1:0]     in_col,
  input  logic [wdsf_pkg::PIX_W-1:0]     in_value,
  input  logic                           cfg_we,
  input  logic [wdsf_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [wdsf_pkg::CFG_W-1:0]     cfg_data,
  input  wdsf_pkg::dp_cmd_t              cmd,
  output wdsf_pkg::dp_sts_t              sts,
  output logic [wdsf_pkg::PIX_W-1:0]     out_read_value,
  output logic                           out_done_res
);

  localparam int RowW  = wdsf_pkg::ROW_W;
  localparam int ColW  = wdsf_pkg::COL_W;
  localparam int DimW  = wdsf_pkg::DIM_W;
  localparam int PixW  = wdsf_pkg::PIX_W;
  localparam int KeepW = wdsf_pkg::KEEP_W;
  localparam int CntW  = wdsf_pkg::CNT_W;
  localparam int CmpW  = wdsf_pkg::CMP_W;
  localparam int AddrW = wdsf_pkg::ADDR_W;

  localparam logic [DimW-1:0] MaxWDim = DimW'(wdsf_pkg::MAX_WIDTH);
  localparam logic [DimW-1:0] MaxHDim = DimW'(wdsf_pkg::MAX_HEIGHT);
  localparam logic [DimW-1:0] RadDim  = DimW'(wdsf_pkg::RADIUS);
  localparam logic [DimW-1:0] SpanDim = DimW'(2 * wdsf_pkg::RADIUS + 1);
  localparam logic [RowW-1:0] RadRow  = RowW'(wdsf_pkg::RADIUS);
  localparam logic [ColW-1:0] RadCol  = ColW'(wdsf_pkg::RADIUS);

  // Configuration registers.
  logic [PixW-1:0]  match_r;
  logic [KeepW-1:0] keep_r;
  logic [DimW-1:0]  width_r;
  logic [DimW-1:0]  height_r;

  // Latched item and run state.
  logic [wdsf_pkg::KIND_W-1:0] kind_r;
  logic [RowW-1:0] row_r;
  logic [ColW-1:0] col_r;
  logic [PixW-1:0] value_r;
  logic [RowW-1:0] r_r, r_nxt;
  logic [ColW-1:0] c_r, c_nxt;
  logic [RowW-1:0] wr_r, wr_nxt;
  logic [ColW-1:0] wc_r, wc_nxt;
  logic [CntW-1:0] cnt_r, cnt_nxt;
  logic            pend_r;
  logic [PixW-1:0] read_value_r;
  logic            done_r;

  // Frame store ports.
  logic             mem_we;
  logic [AddrW-1:0] mem_waddr;
  logic [PixW-1:0]  mem_wdata;
  logic [AddrW-1:0] mem_raddr;
  logic [PixW-1:0]  mem_rdata;

  logic [DimW-1:0] w_eff, h_eff, c_max, r_max;
  logic            c_at_max, r_at_max;
  logic            wc_at_end, wr_at_end;
  logic            pix_fg;

  // Active area clamped to the store, and the last centre row and column.
  assign w_eff    = (width_r > MaxWDim) ? MaxWDim : width_r;
  assign h_eff    = (height_r > MaxHDim) ? MaxHDim : height_r;
  assign c_max    = w_eff - RadDim - DimW'(1);
  assign r_max    = h_eff - RadDim - DimW'(1);
  assign c_at_max = (DimW'(c_r) == c_max);
  assign r_at_max = (DimW'(r_r) == r_max);

  // Last window column and row hold centre plus RADIUS minus one.
  assign wc_at_end = (wc_r == c_r + RadCol - ColW'(1));
  assign wr_at_end = (wr_r == r_r + RadRow - RowW'(1));
  assign pix_fg    = (mem_rdata == match_r);

  assign sts.size_ok  = (w_eff >= SpanDim) && (h_eff >= SpanDim);
  assign sts.ctr_fg   = pix_fg;
  assign sts.win_last = wc_at_end && wr_at_end;
  assign sts.keep_low = (CmpW'(cnt_r) <= CmpW'(keep_r));
  assign sts.ctr_last = c_at_max && r_at_max;

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      match_r  <= wdsf_pkg::MATCH_RST;
      keep_r   <= wdsf_pkg::KEEP_RST;
      width_r  <= wdsf_pkg::WIDTH_RST;
      height_r <= wdsf_pkg::HEIGHT_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        wdsf_pkg::CFG_MATCH:  match_r  <= cfg_data[PixW-1:0];
        wdsf_pkg::CFG_KEEP:   keep_r   <= cfg_data[KeepW-1:0];
        wdsf_pkg::CFG_WIDTH:  width_r  <= cfg_data[DimW-1:0];
        wdsf_pkg::CFG_HEIGHT: height_r <= cfg_data[DimW-1:0];
      endcase
    end
  end

  // Item latch.
  always_ff @(posedge clk) begin
    if (cmd.item_load) begin
      kind_r  <= in_kind;
      row_r   <= in_row;
      col_r   <= in_col;
      value_r <= in_value;
    end
  end

  // Centre and window coordinates, and the window count.
  always_comb begin
    r_nxt   = r_r;
    c_nxt   = c_r;
    wr_nxt  = wr_r;
    wc_nxt  = wc_r;
    cnt_nxt = cnt_r;
    if (cmd.run_init) begin
      r_nxt = RadRow;
      c_nxt = RadCol;
    end else if (cmd.ctr_step) begin
      if (c_at_max) begin
        c_nxt = RadCol;
        r_nxt = r_r + RowW'(1);
      end else begin
        c_nxt = c_r + ColW'(1);
      end
    end
    if (cmd.win_init) begin
      wr_nxt = r_r - RadRow;
      wc_nxt = c_r - RadCol;
    end else if (cmd.win_step) begin
      if (wc_at_end) begin
        wc_nxt = c_r - RadCol;
        wr_nxt = wr_r + RowW'(1);
      end else begin
        wc_nxt = wc_r + ColW'(1);
      end
    end
    // Read data of a window address arrives in the cycle after its read.
    if (cmd.win_init) begin
      cnt_nxt = '0;
    end else if (pend_r && pix_fg) begin
      cnt_nxt = cnt_r + CntW'(1);
    end
  end

  always_ff @(posedge clk) begin
    r_r   <= r_nxt;
    c_r   <= c_nxt;
    wr_r  <= wr_nxt;
    wc_r  <= wc_nxt;
    cnt_r <= cnt_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r <= 1'b0;
    end else begin
      pend_r <= cmd.win_step;
    end
  end

  // Frame store: item writes, centre clears, and one read address.
  assign mem_we    = cmd.item_wr || cmd.clear_wr;
  assign mem_waddr = cmd.clear_wr ? {r_r, c_r} : {row_r, col_r};
  assign mem_wdata = cmd.clear_wr ? '0 : value_r;

  always_comb begin
    unique case (cmd.rd_src)
      wdsf_pkg::RD_CTR: mem_raddr = {r_r, c_r};
      wdsf_pkg::RD_WIN: mem_raddr = {wr_r, wc_r};
      default:          mem_raddr = {row_r, col_r};
    endcase
  end

  wdsf_ram #(
    .DataW (PixW),
    .Depth (wdsf_pkg::DEPTH)
  ) u_frame (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (cmd.rd_en),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  // Result register.
  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      read_value_r <= (kind_r == wdsf_pkg::KIND_READ) ? mem_rdata : '0;
      done_r       <= (kind_r == wdsf_pkg::KIND_RUN);
    end
  end

  assign out_read_value = read_value_r;
  assign out_done_res   = done_r;

endmodule

/* sv/window_density_speckle_filter_top.sv */
// Top level of the window density speckle filter.
// Depends on wdsf_pkg, wdsf_in_if, wdsf_out_if, wdsf_ctrl, wdsf_dp and assert_macros.svh.
//
// Usage: the block holds one 256 x 256 slice of 16-bit pixels. Each beat on
// in_chan is one item: kind write stores value at (row, col), kind read
// returns the pixel at (row, col), kind run filters the slice in place. Every
// item gives exactly one beat on out_chan: read_value carries the pixel for
// reads and is zero otherwise, done_res is set for a run. The cfg port sets
// match value, keep threshold, width and height; the user writes it only
// while the block is idle, which the block does not enforce. A write or a
// read goes through its own state, then the done state; an unused kind goes
// straight there. A run checks each centre and reads the 40 x 40 window of a
// foreground centre one pixel a cycle through the single frame store read
// port. One item is in flight at a time: in_chan.ready is high only while
// idle. The result sits in an output register, so a stalled receiver holds
// the result beat there and the next item waits until it can be placed.
// Reset clears the controller and restores the register reset values; the
// frame store content is undefined until written.
`include "assert_macros.svh"

module window_density_speckle_filter_top (
  input  logic                           clk,
  input  logic                           rst_n,
  wdsf_in_if.sink                        in_chan,
  wdsf_out_if.source                     out_chan,
  input  logic                           cfg_we,
  input  logic [wdsf_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [wdsf_pkg::CFG_W-1:0]     cfg_data
);

  wdsf_pkg::dp_cmd_t cmd;
  wdsf_pkg::dp_sts_t sts;

  // Controller: handshakes and sequencing.
  wdsf_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_chan.valid),
    .in_kind   (in_chan.kind),
    .in_ready  (in_chan.ready),
    .out_valid (out_chan.valid),
    .out_ready (out_chan.ready),
    .cmd       (cmd),
    .sts       (sts)
  );

  // Datapath: registers, frame store and window counter.
  wdsf_dp u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_kind        (in_chan.kind),
    .in_row         (in_chan.row),
    .in_col         (in_chan.col),
    .in_value       (in_chan.value),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .cmd            (cmd),
    .sts            (sts),
    .out_read_value (out_chan.read_value),
    .out_done_res   (out_chan.done_res)
  );

  // An accepted item keeps the block busy for at least the next cycle.
  `WDSF_ASSERT_NXT(a_busy_after_accept, in_chan.valid && in_chan.ready, !in_chan.ready)
  // A run result never carries pixel data.
  `WDSF_ASSERT_IMP(a_run_no_data, out_chan.valid && out_chan.done_res, out_chan.read_value == '0)
  // A new result beat appears only while an item was being worked on.
  `WDSF_ASSERT_IMP(a_result_from_item, $rose(out_chan.valid), $past(!in_chan.ready))
  // A centre clear happens only at the end of a window count.
  `WDSF_ASSERT_IMP(a_clear_after_count, cmd.clear_wr, $past(!cmd.win_step) && !cmd.item_wr)

endmodule

/* bench/despeckle_checker.sv */
// Checker for the window density speckle filter: watches the item, result and
// register ports, keeps its own frame and register copies and compares beats.
// Depends on wdsf_pkg and the wdsf_in_if and wdsf_out_if interfaces.
module despeckle_checker (
  input  logic                           clk,
  input  logic                           rst_n,
  wdsf_in_if                             in_mon,
  wdsf_out_if                            out_mon,
  input  logic                           cfg_we,
  input  logic [wdsf_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [wdsf_pkg::CFG_W-1:0]     cfg_data,
  output int unsigned                    outstanding,
  output int unsigned                    mismatches
);
  import wdsf_pkg::*;

  typedef struct packed {
    logic [PIX_W-1:0] read_value;
    logic             done_res;
  } answer_t;

  // Shadow copy of the frame and of the four registers.
  logic [PIX_W-1:0]  shadow_frame [0:DEPTH-1];
  logic [PIX_W-1:0]  fg_value;
  logic [KEEP_W-1:0] keep_limit;
  logic [DIM_W-1:0]  cols_used;
  logic [DIM_W-1:0]  rows_used;
  answer_t           due_answers [$];

  // Filter the shadow slice in place, centre by centre in raster order, so
  // that a clearing is seen by every later window.
  function automatic void despeckle_slice();
    int w;
    int h;
    int count;
    w = (cols_used > MAX_WIDTH) ? MAX_WIDTH : int'(cols_used);
    h = (rows_used > MAX_HEIGHT) ? MAX_HEIGHT : int'(rows_used);
    if (w < 2 * RADIUS + 1 || h < 2 * RADIUS + 1) return;
    for (int r = RADIUS; r + RADIUS < h; r++) begin
      for (int c = RADIUS; c + RADIUS < w; c++) begin
        if (shadow_frame[r * MAX_WIDTH + c] == fg_value) begin
          count = 0;
          for (int wr = r - RADIUS; wr < r + RADIUS; wr++)
            for (int wc = c - RADIUS; wc < c + RADIUS; wc++)
              if (shadow_frame[wr * MAX_WIDTH + wc] == fg_value) count++;
          if (count <= keep_limit) shadow_frame[r * MAX_WIDTH + c] = '0;
        end
      end
    end
  endfunction

  // Apply one item to the shadow state and return the beat it should produce.
  function automatic answer_t predict_item(logic [KIND_W-1:0] kind, logic [ROW_W-1:0] row,
                                           logic [COL_W-1:0] col, logic [PIX_W-1:0] value);
    answer_t ans;
    ans = '0;
    case (kind)
      KIND_WRITE: shadow_frame[{row, col}] = value;
      KIND_RUN: begin
        despeckle_slice();
        ans.done_res = 1'b1;
      end
      KIND_READ: ans.read_value = shadow_frame[{row, col}];
      default: ;
    endcase
    return ans;
  endfunction

  function automatic void check_field(string name, logic [PIX_W-1:0] want, logic [PIX_W-1:0] got);
    if (got !== want) begin
      $error("%s mismatch: expected %0h, got %0h", name, want, got);
      mismatches++;
    end
  endfunction

  // Everything is sampled at the rising edge; the stimulus moves on the falling one.
  always @(posedge clk) begin
    answer_t want;
    if (!rst_n) begin
      fg_value    = MATCH_RST;
      keep_limit  = KEEP_RST;
      cols_used   = WIDTH_RST;
      rows_used   = HEIGHT_RST;
      due_answers.delete();
      mismatches  = 0;
    end else begin
      // Result beat against the oldest waiting answer.
      if (out_mon.valid && out_mon.ready) begin
        if (due_answers.size() == 0) begin
          $error("result beat with no item waiting: read_value %0h, done_res %0b",
                 out_mon.read_value, out_mon.done_res);
          mismatches++;
        end else begin
          want = due_answers.pop_front();
          check_field("read_value", want.read_value, out_mon.read_value);
          check_field("done_res", PIX_W'(want.done_res), PIX_W'(out_mon.done_res));
        end
      end

      // Item beat: predict its answer now, in acceptance order.
      if (in_mon.valid && in_mon.ready)
        due_answers.push_back(predict_item(in_mon.kind, in_mon.row, in_mon.col, in_mon.value));

      // Register writes.
      if (cfg_we) begin
        case (cfg_index)
          CFG_MATCH:  fg_value   = cfg_data[PIX_W-1:0];
          CFG_KEEP:   keep_limit = cfg_data[KEEP_W-1:0];
          CFG_WIDTH:  cols_used  = cfg_data[DIM_W-1:0];
          CFG_HEIGHT: rows_used  = cfg_data[DIM_W-1:0];
          default: ;
        endcase
      end
    end
    outstanding = due_answers.size();
  end

endmodule

/* bench/tb_top.sv */
// Top of the speckle filter bench: clock, reset, item and register stimulus,
// result back-pressure and the verdict.
// Depends on wdsf_pkg, the channel interfaces, the RTL top and despeckle_checker.
module tb_top;
  import wdsf_pkg::*;

  // Kind code that the block does not use.
  localparam logic [KIND_W-1:0] KIND_SPARE = 2'd3;
  localparam int RANDOM_ITEMS  = 500;
  localparam int PHASE_ITEMS   = 45;
  localparam int FULL_WINDOW   = 4 * RADIUS * RADIUS;
  localparam int SETTLE_CYCLES = 20;

  logic                 clk;
  logic                 rst_n;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0]     cfg_data;
  int unsigned          outstanding;
  int unsigned          mismatches;
  bit                   calm;
  int unsigned          random_sent;
  logic [PIX_W-1:0]     fg_now;
  bit                   written [0:DEPTH-1];
  int unsigned          written_list [$];

  wdsf_in_if  in_chan ();
  wdsf_out_if out_chan ();

  window_density_speckle_filter_top u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_chan   (in_chan),
    .out_chan  (out_chan),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  despeckle_checker u_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_mon      (in_chan),
    .out_mon     (out_chan),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .outstanding (outstanding),
    .mismatches  (mismatches)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Hard stop well past the slowest correct run.
  initial begin
    #100000000;
    $display("TEST FAILED");
    $finish;
  end

  // Result side back-pressure: random stall bursts, none once the run is calm.
  initial begin
    int unsigned hold;
    hold = 0;
    out_chan.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold != 0) begin
        hold--;
        out_chan.ready <= 1'b0;
      end else if (!calm && $urandom_range(0, 5) == 0) begin
        hold = $urandom_range(0, 10);
        out_chan.ready <= 1'b0;
      end else begin
        out_chan.ready <= 1'b1;
      end
    end
  end

  // Offer one item, possibly after an idle burst, and return once the beat is taken.
  task automatic send_item(logic [KIND_W-1:0] kind, logic [ROW_W-1:0] row,
                           logic [COL_W-1:0] col, logic [PIX_W-1:0] value);
    int unsigned gap;
    int unsigned addr;
    gap  = (!calm && $urandom_range(0, 4) == 0) ? $urandom_range(1, 11) : 0;
    addr = 32'({row, col});
    if (kind == KIND_WRITE && !written[addr]) begin
      written[addr] = 1'b1;
      written_list.push_back(addr);
    end
    if (gap != 0) begin
      @(negedge clk);
      in_chan.valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_chan.valid <= 1'b1;
    in_chan.kind  <= kind;
    in_chan.row   <= row;
    in_chan.col   <= col;
    in_chan.value <= value;
    @(posedge clk);
    while (!in_chan.ready) @(posedge clk);
  endtask

  task automatic start_run();
    send_item(KIND_RUN, ROW_W'($urandom), COL_W'($urandom), PIX_W'($urandom));
  endtask

  // Drop the item valid and wait until every result beat has come back.
  task automatic drain();
    @(negedge clk);
    in_chan.valid <= 1'b0;
    while (outstanding != 0) @(negedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(negedge clk);
    cfg_we    <= 1'b0;
  endtask

  // Set all four registers once the block is idle.
  task automatic configure(logic [PIX_W-1:0] fg, int keep, int unsigned w, int unsigned h);
    drain();
    fg_now = fg;
    write_reg(CFG_MATCH, fg);
    write_reg(CFG_KEEP, CFG_W'(keep));
    write_reg(CFG_WIDTH, CFG_W'(w));
    write_reg(CFG_HEIGHT, CFG_W'(h));
  endtask

  // A pixel that is never the foreground value: zero, a near miss, or anything.
  function automatic logic [PIX_W-1:0] background_pixel();
    logic [PIX_W-1:0] v;
    case ($urandom_range(0, 3))
      0:       v = '0;
      1:       v = fg_now ^ (PIX_W'(1) << $urandom_range(0, PIX_W - 1));
      default: v = PIX_W'($urandom);
    endcase
    if (v == fg_now) v = ~fg_now;
    return v;
  endfunction

  function automatic logic [PIX_W-1:0] pattern_pixel(int unsigned density);
    return ($urandom_range(0, 99) < density) ? fg_now : background_pixel();
  endfunction

  task automatic fill_rect(int unsigned r0, int unsigned r1, int unsigned c0, int unsigned c1,
                           int unsigned density);
    for (int unsigned r = r0; r <= r1; r++)
      for (int unsigned c = c0; c <= c1; c++)
        send_item(KIND_WRITE, ROW_W'(r), COL_W'(c), pattern_pixel(density));
  endtask

  // Address along a line across (a) and along (b) the long side of a clamped slice.
  task automatic place(bit tall, logic [KIND_W-1:0] kind, int unsigned a, int unsigned b,
                       logic [PIX_W-1:0] v);
    if (tall) send_item(kind, ROW_W'(b), COL_W'(a), v);
    else send_item(kind, ROW_W'(a), COL_W'(b), v);
  endtask

  // One dimension beyond the store and the other at the minimum: the only
  // centre line runs to the clamped edge, foreground only near its far end.
  task automatic clamped_phase(bit tall);
    int unsigned density;
    int unsigned span;
    int          keep;
    density = $urandom_range(70, 95);
    span    = tall ? MAX_HEIGHT : MAX_WIDTH;
    keep    = int'(density) * FULL_WINDOW / 100 + int'($urandom_range(0, 80)) - 40;
    configure(PIX_W'($urandom), keep, tall ? 2 * RADIUS + 1 : 511, tall ? 300 : 2 * RADIUS + 1);
    for (int unsigned a = 0; a <= 2 * RADIUS; a++)
      for (int unsigned b = span - 50; b < span; b++)
        place(tall, KIND_WRITE, a, b, pattern_pixel(density));
    for (int unsigned b = RADIUS; b < span - RADIUS - 8; b++)
      place(tall, KIND_WRITE, RADIUS, b, background_pixel());
    start_run();
    for (int unsigned b = span - RADIUS - 8; b < span - RADIUS; b++)
      place(tall, KIND_READ, RADIUS, b, PIX_W'($urandom));
  endtask

  // Load a fresh slice, mix writes, reads, spare items and runs, then filter and read back.
  task automatic random_phase();
    int unsigned w;
    int unsigned h;
    int unsigned density;
    int unsigned pick;
    int unsigned addr;
    int          keep;
    logic [PIX_W-1:0] fg;
    w       = $urandom_range(2 * RADIUS + 1, 2 * RADIUS + 5);
    h       = $urandom_range(2 * RADIUS + 1, 2 * RADIUS + 5);
    density = $urandom_range(30, 100);
    case ($urandom_range(0, 5))
      0:       fg = '0;
      1:       fg = '1;
      2:       fg = MATCH_RST;
      default: fg = PIX_W'($urandom);
    endcase
    case ($urandom_range(0, 7))
      0:       keep = 0;
      1:       keep = 8191;
      2:       keep = 4096;
      3:       keep = FULL_WINDOW;
      default: keep = int'(density) * FULL_WINDOW / 100 + int'($urandom_range(0, 120)) - 60;
    endcase
    if (keep < 0) keep = 0;
    configure(fg, keep, w, h);
    fill_rect(0, h - 1, 0, w - 1, density);

    repeat (PHASE_ITEMS) begin
      pick = $urandom_range(0, 99);
      if (pick < 35) begin
        send_item(KIND_WRITE, ROW_W'($urandom_range(0, h - 1)), COL_W'($urandom_range(0, w - 1)),
                  pattern_pixel(density));
      end else if (pick < 50) begin
        send_item(KIND_WRITE, ROW_W'($urandom), COL_W'($urandom),
                  ($urandom_range(0, 3) == 0) ? fg_now : PIX_W'($urandom));
      end else if (pick < 88) begin
        addr = written_list[$urandom_range(0, written_list.size() - 1)];
        send_item(KIND_READ, addr[15:8], addr[7:0], PIX_W'($urandom));
      end else if (pick < 96) begin
        send_item(KIND_SPARE, ROW_W'($urandom), COL_W'($urandom), PIX_W'($urandom));
      end else begin
        start_run();
      end
    end

    start_run();
    repeat (5)
      send_item(KIND_READ, ROW_W'($urandom_range(RADIUS, h - 1 - RADIUS)),
                COL_W'($urandom_range(RADIUS, w - 1 - RADIUS)), PIX_W'($urandom));
    random_sent += PHASE_ITEMS + 6;
  endtask

  initial begin
    in_chan.valid = 1'b0;
    in_chan.kind  = KIND_WRITE;
    in_chan.row   = '0;
    in_chan.col   = '0;
    in_chan.value = '0;
    cfg_we        = 1'b0;
    cfg_index     = CFG_MATCH;
    cfg_data      = '0;
    calm          = 1'b0;
    random_sent   = 0;
    fg_now        = MATCH_RST;
    rst_n         = 1'b0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Corners of the store, the spare kind, and reads back.
    send_item(KIND_WRITE, 8'h00, 8'h00, 16'h0000);
    send_item(KIND_WRITE, 8'hFF, 8'hFF, 16'hFFFF);
    send_item(KIND_WRITE, 8'h00, 8'hFF, 16'hA5A5);
    send_item(KIND_WRITE, 8'hFF, 8'h00, 16'h5A5A);
    send_item(KIND_SPARE, 8'hFF, 8'hFF, 16'h1234);
    send_item(KIND_READ, 8'hFF, 8'hFF, 16'h0000);
    send_item(KIND_READ, 8'h00, 8'h00, 16'hFFFF);
    send_item(KIND_READ, 8'h00, 8'hFF, 16'h0000);
    send_item(KIND_READ, 8'hFF, 8'h00, 16'h0000);

    // Slices too small for any centre, with zero and oversized dimensions.
    configure(MATCH_RST, KEEP_RST, 0, 256);
    start_run();
    configure(MATCH_RST, KEEP_RST, 2 * RADIUS, 2 * RADIUS);
    start_run();
    configure(MATCH_RST, KEEP_RST, 511, 1);
    start_run();
    configure(MATCH_RST, KEEP_RST, 256, 0);
    start_run();

    // Smallest slice with a centre, all foreground: cleared at a threshold of
    // a full window, kept one below it.
    configure(16'hFFFF, FULL_WINDOW, 2 * RADIUS + 1, 2 * RADIUS + 1);
    fill_rect(0, 2 * RADIUS, 0, 2 * RADIUS, 100);
    start_run();
    send_item(KIND_READ, ROW_W'(RADIUS), COL_W'(RADIUS), 16'h0000);
    configure(16'hFFFF, FULL_WINDOW - 1, 2 * RADIUS + 1, 2 * RADIUS + 1);
    send_item(KIND_WRITE, ROW_W'(RADIUS), COL_W'(RADIUS), 16'hFFFF);
    start_run();
    send_item(KIND_READ, ROW_W'(RADIUS), COL_W'(RADIUS), 16'h0000);

    // Width, then height, beyond the store.
    clamped_phase(1'b0);
    clamped_phase(1'b1);

    // Random slices; the last stretch runs without idling on either side.
    while (random_sent < RANDOM_ITEMS) begin
      if (random_sent >= RANDOM_ITEMS * 85 / 100) calm = 1'b1;
      random_phase();
    end

    drain();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatches == 0 && outstanding == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
